// File: sv/smavg_pkg.sv
// ============================================================================
// smavg_pkg: shared types and constants for the moving average filter
// Widths, state encodings, the job record and the window saturation helper.
// ============================================================================
package smavg_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int CFG_W       = 7;
  localparam int POS_W       = $clog2(MAX_WINDOW);
  localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W       = SAMPLE_BITS + POS_W;
  localparam int DIV_STEPS   = SUM_W;
  localparam int STEP_W      = $clog2(DIV_STEPS + 1);
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);

  localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(8);

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef enum logic [0:0] {
    F_IDLE,
    F_UPDATE
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } back_state_e;

  // One division job: window sum, divisor and the filled flag to report.
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        count;
    logic                    filled;
  } job_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QPTR_W:0]   level;
  } q_stat_t;

  // Zero acts as a window of one, anything above the store size saturates.
  function automatic logic [CNT_W-1:0] eff_window(input logic [CFG_W-1:0] wl);
    logic [CNT_W-1:0] w;
    if (wl == '0) begin
      w = CNT_W'(1);
    end else if (int'(wl) > MAX_WINDOW) begin
      w = CNT_W'(MAX_WINDOW);
    end else begin
      w = CNT_W'(wl);
    end
    return w;
  endfunction

endpackage

// File: sv/smavg_if.sv
// ============================================================================
// smavg_if: handshake channels of the moving average filter
// Request, result and configuration channels, valid/ready each.
// ============================================================================
interface smavg_req_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   cmd;
  logic signed [smavg_pkg::SAMPLE_BITS-1:0] sample;

  modport source (output valid, output cmd, output sample, input ready);
  modport sink   (input valid, input cmd, input sample, output ready);
endinterface

interface smavg_res_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [smavg_pkg::SAMPLE_BITS-1:0] average;
  logic                                   window_filled;

  modport source (output valid, output average, output window_filled, input ready);
  modport sink   (input valid, input average, input window_filled, output ready);
endinterface

interface smavg_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [smavg_pkg::CFG_W-1:0]   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/smavg_ram.sv
// ============================================================================
// smavg_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ============================================================================
module smavg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/smavg_front.sv
// ============================================================================
// smavg_front: request intake and window bookkeeping
// Handles clears and config, keeps the ring store and running sum, and
// issues one division job per sample.
// ============================================================================
module smavg_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  smavg_req_if.sink           req,
  smavg_cfg_if.sink           cfg,
  input  smavg_pkg::q_stat_t  q_stat_i,
  output logic                push_o,
  output smavg_pkg::job_t     job_o
);

  smavg_pkg::front_state_e state_q, state_d;

  logic [smavg_pkg::CFG_W-1:0]            win_q;
  logic [smavg_pkg::POS_W-1:0]            pos_q;
  logic                                   filled_q;
  logic signed [smavg_pkg::SUM_W-1:0]     sum_q;
  logic [smavg_pkg::MAX_WINDOW-1:0]       vld_q;
  logic signed [smavg_pkg::SAMPLE_BITS-1:0] sample_q;
  logic                                   old_vld_q;

  logic                                   accept;
  logic                                   do_clear;
  logic                                   rd_en;
  logic [smavg_pkg::SAMPLE_BITS-1:0]      ram_rdata;
  logic signed [smavg_pkg::SAMPLE_BITS-1:0] old_val;
  logic signed [smavg_pkg::SUM_W-1:0]     sum_new;
  logic [smavg_pkg::CNT_W-1:0]            win_eff;
  logic [smavg_pkg::CNT_W-1:0]            pos_inc;
  logic                                   wrap;
  logic                                   filled_new;
  logic [smavg_pkg::POS_W-1:0]            pos_new;

  assign cfg.ready = 1'b1;
  assign req.ready = (state_q == smavg_pkg::F_IDLE);
  assign accept    = req.valid && req.ready;
  assign rd_en     = accept && (req.cmd == smavg_pkg::CMD_SAMPLE);
  assign do_clear  = (accept && (req.cmd == smavg_pkg::CMD_CLEAR)) ||
                     (cfg.valid && cfg.ready);

  smavg_ram #(
    .WIDTH (smavg_pkg::SAMPLE_BITS),
    .DEPTH (smavg_pkg::MAX_WINDOW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (push_o),
    .waddr_i (pos_q),
    .wdata_i (sample_q),
    .re_i    (rd_en),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    win_eff    = smavg_pkg::eff_window(win_q);
    old_val    = old_vld_q ? $signed(ram_rdata) : '0;
    sum_new    = sum_q
               - {{(smavg_pkg::SUM_W-smavg_pkg::SAMPLE_BITS){old_val[smavg_pkg::SAMPLE_BITS-1]}},
                  old_val}
               + {{(smavg_pkg::SUM_W-smavg_pkg::SAMPLE_BITS){sample_q[smavg_pkg::SAMPLE_BITS-1]}},
                  sample_q};
    pos_inc    = smavg_pkg::CNT_W'(pos_q) + smavg_pkg::CNT_W'(1);
    wrap       = (pos_inc >= win_eff);
    filled_new = filled_q || wrap;
    pos_new    = wrap ? '0 : pos_inc[smavg_pkg::POS_W-1:0];

    job_o.sum    = sum_new;
    job_o.count  = filled_new ? win_eff : pos_inc;
    job_o.filled = filled_new;
  end

  always_comb begin
    state_d = state_q;
    push_o  = 1'b0;
    case (state_q)
      smavg_pkg::F_IDLE: begin
        if (rd_en) begin
          state_d = smavg_pkg::F_UPDATE;
        end
      end
      smavg_pkg::F_UPDATE: begin
        if (!q_stat_i.full) begin
          push_o  = 1'b1;
          state_d = smavg_pkg::F_IDLE;
        end
      end
      default: begin
        state_d = smavg_pkg::F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= smavg_pkg::F_IDLE;
      win_q    <= smavg_pkg::WINDOW_RESET;
      pos_q    <= '0;
      filled_q <= 1'b0;
      sum_q    <= '0;
      vld_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg.valid && cfg.ready) begin
        win_q <= cfg.data;
      end
      if (do_clear) begin
        pos_q    <= '0;
        filled_q <= 1'b0;
        sum_q    <= '0;
        vld_q    <= '0;
      end else if (push_o) begin
        pos_q        <= pos_new;
        filled_q     <= filled_new;
        sum_q        <= sum_new;
        vld_q[pos_q] <= 1'b1;
      end
    end
  end

  // Sample and old-entry flag captured with the request.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      sample_q  <= req.sample;
      old_vld_q <= vld_q[pos_q];
    end
  end

endmodule

// File: sv/smavg_queue.sv
// ============================================================================
// smavg_queue: short job queue between front and back
// Small register FIFO of division jobs with full/empty/level status.
// ============================================================================
module smavg_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  smavg_pkg::job_t     job_i,
  input  logic                pop_i,
  output smavg_pkg::job_t     job_o,
  output smavg_pkg::q_stat_t  stat_o
);

  smavg_pkg::job_t             slot_q [smavg_pkg::QDEPTH];
  logic [smavg_pkg::QPTR_W-1:0] wr_ptr_q;
  logic [smavg_pkg::QPTR_W-1:0] rd_ptr_q;
  logic [smavg_pkg::QPTR_W:0]   level_q;
  logic                         do_push;
  logic                         do_pop;

  assign stat_o.full  = (level_q == (smavg_pkg::QPTR_W+1)'(smavg_pkg::QDEPTH));
  assign stat_o.empty = (level_q == '0);
  assign stat_o.level = level_q;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign job_o        = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == smavg_pkg::QPTR_W'(smavg_pkg::QDEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == smavg_pkg::QPTR_W'(smavg_pkg::QDEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   level_q <= level_q + 1'b1;
        2'b01:   level_q <= level_q - 1'b1;
        default: level_q <= level_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// File: sv/smavg_back.sv
// ============================================================================
// smavg_back: serial divider and result register
// Restoring division of |sum| by the count, one quotient bit per cycle,
// sign restored at the end; result held in an output register.
// ============================================================================
module smavg_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  smavg_pkg::job_t     job_i,
  input  smavg_pkg::q_stat_t  q_stat_i,
  output logic                pop_o,
  smavg_res_if.source         res
);

  smavg_pkg::back_state_e state_q, state_d;

  logic [smavg_pkg::SUM_W-1:0]            dvd_q;
  logic [smavg_pkg::CNT_W-1:0]            div_q;
  logic [smavg_pkg::CNT_W-1:0]            rem_q;
  logic                                   neg_q;
  logic                                   filled_q;
  logic [smavg_pkg::STEP_W-1:0]           step_q;
  logic                                   res_vld_q;
  logic signed [smavg_pkg::SAMPLE_BITS-1:0] avg_q;
  logic                                   wf_q;

  logic [smavg_pkg::CNT_W:0]              trial;
  logic                                   qbit;
  logic [smavg_pkg::CNT_W:0]              trial_sub;
  logic [smavg_pkg::SUM_W-1:0]            mag_in;
  logic [smavg_pkg::SUM_W-1:0]            quo_signed;
  logic                                   load_res;
  logic                                   last_step;

  always_comb begin
    mag_in     = job_i.sum[smavg_pkg::SUM_W-1] ? (~job_i.sum + 1'b1) : job_i.sum;
    trial      = {rem_q, dvd_q[smavg_pkg::SUM_W-1]};
    qbit       = (trial >= {1'b0, div_q});
    trial_sub  = trial - {1'b0, div_q};
    quo_signed = neg_q ? (~dvd_q + 1'b1) : dvd_q;
    last_step  = (step_q == smavg_pkg::STEP_W'(smavg_pkg::DIV_STEPS-1));
  end

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    load_res = 1'b0;
    case (state_q)
      smavg_pkg::B_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o   = 1'b1;
          state_d = smavg_pkg::B_DIV;
        end
      end
      smavg_pkg::B_DIV: begin
        if (last_step) begin
          state_d = smavg_pkg::B_DONE;
        end
      end
      smavg_pkg::B_DONE: begin
        if (!res_vld_q || res.ready) begin
          load_res = 1'b1;
          state_d  = smavg_pkg::B_IDLE;
        end
      end
      default: begin
        state_d = smavg_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= smavg_pkg::B_IDLE;
      res_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_res) begin
        res_vld_q <= 1'b1;
      end else if (res.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      dvd_q    <= mag_in;
      div_q    <= job_i.count;
      rem_q    <= '0;
      neg_q    <= job_i.sum[smavg_pkg::SUM_W-1];
      filled_q <= job_i.filled;
      step_q   <= '0;
    end else if (state_q == smavg_pkg::B_DIV) begin
      rem_q  <= qbit ? trial_sub[smavg_pkg::CNT_W-1:0] : trial[smavg_pkg::CNT_W-1:0];
      dvd_q  <= {dvd_q[smavg_pkg::SUM_W-2:0], qbit};
      step_q <= step_q + 1'b1;
    end
    if (load_res) begin
      avg_q <= quo_signed[smavg_pkg::SAMPLE_BITS-1:0];
      wf_q  <= filled_q;
    end
  end

  assign res.valid         = res_vld_q;
  assign res.average       = avg_q;
  assign res.window_filled = wf_q;

endmodule

// File: sv/simple_moving_average.sv
// ============================================================================
// simple_moving_average: moving average filter, top level
// Front end keeps the ring store and running sum; a two-entry job queue
// feeds a serial divider that produces the truncated mean.
// ============================================================================
//
//  channel  dir  handshake        payload
//  -------  ---  ---------------  ------------------------------------------
//  req_i    in   valid / ready    cmd (0 sample, 1 clear), sample (s16)
//  res_o    out  valid / ready    average (s16), window_filled
//  cfg_i    in   valid / ready    data = window_length (7 bits), always ready
//
//  A sample request passes through the front end as a store read, then a
//  store write plus sum update that waits while the queue is full; the
//  divider then pops the job, computes the quotient bit by bit and loads the
//  result, and pops no new job before that load. A clear produces no result.
//  Reset zeros sum, position, filled flag and the per-entry valid bits at
//  once, so no clearing pass is needed. The result register lets the
//  divider finish while a stalled result waits, and the queue lets the
//  front end take requests while the divider is busy.
//
module simple_moving_average (
  input  logic         clk_i,
  input  logic         rst_ni,
  smavg_req_if.sink    req_i,
  smavg_res_if.source  res_o,
  smavg_cfg_if.sink    cfg_i
);

  smavg_pkg::job_t    push_job;
  smavg_pkg::job_t    pop_job;
  smavg_pkg::q_stat_t q_stat;
  logic               push;
  logic               pop;

  // Front: intake, clears, config, ring store and running sum.
  smavg_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req      (req_i),
    .cfg      (cfg_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .job_o    (push_job)
  );

  // Jobs waiting for the divider.
  smavg_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (pop_job),
    .stat_o (q_stat)
  );

  // Back: serial divide and result register.
  smavg_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .job_i    (pop_job),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .res      (res_o)
  );

`ifndef SYNTHESIS
  // Front must hold off while the queue is full.
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("job pushed into a full queue");

  // Divider never pops from an empty queue.
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("job popped from an empty queue");

  // Divisor is always in 1..MAX_WINDOW.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (push_job.count != '0) &&
             (int'(push_job.count) <= smavg_pkg::MAX_WINDOW))
    else $error("divisor out of range");

  // Queue level rises by one on a push without a pop.
  a_level_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (q_stat.level == $past(q_stat.level) + 1'b1))
    else $error("queue level did not advance on push");
`endif

endmodule

// File: dv/simple_moving_average_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// simple_moving_average_tb: self-checking bench for the moving average filter
// Drives sample and clear requests plus window length writes, predicts each
// mean in a behavioral model of the ring store, and checks every result.
// ============================================================================
module simple_moving_average_tb;

  localparam int    CLK_PERIOD   = 20;
  // Front end plus divider plus margin: covers a clear still in flight.
  localparam int    DRAIN_CYCLES = 40;
  localparam longint TIMEOUT_NS  = 64'd10_000_000;

  typedef struct packed {
    logic signed [smavg_pkg::SAMPLE_BITS-1:0] average;
    logic                                     window_filled;
  } mean_t;

  logic clk_i;
  logic rst_ni;

  smavg_req_if req_if ();
  smavg_res_if res_if ();
  smavg_cfg_if cfg_if ();

  simple_moving_average u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // --------------------------------------------------------------------------
  // Behavioral copy of the filter state
  // --------------------------------------------------------------------------
  logic [smavg_pkg::CFG_W-1:0]              win_len_q;
  logic signed [smavg_pkg::SAMPLE_BITS-1:0] ring [smavg_pkg::MAX_WINDOW];
  int                                       ring_sum;
  int                                       ring_pos;
  bit                                       ring_full;

  mean_t expected_means [$];
  int    n_errors = 0;
  // Set for the final stretch: no idling on either side.
  bit    quiet = 1'b0;

  function automatic void clear_ring();
    foreach (ring[i]) ring[i] = '0;
    ring_sum  = 0;
    ring_pos  = 0;
    ring_full = 1'b0;
  endfunction

  // Zero behaves as a window of one; lengths above the store saturate.
  function automatic int window_size();
    if (win_len_q == '0) return 1;
    if (int'(win_len_q) > smavg_pkg::MAX_WINDOW) return smavg_pkg::MAX_WINDOW;
    return int'(win_len_q);
  endfunction

  // Applies one accepted request to the model; a sample queues its mean.
  function automatic void predict_mean(input logic cmd,
                                       input logic signed [smavg_pkg::SAMPLE_BITS-1:0] smp);
    int    win;
    int    pos;
    int    count;
    int    avg;
    mean_t m;
    win = window_size();
    if (cmd == smavg_pkg::CMD_CLEAR) begin
      clear_ring();
      return;
    end
    pos      = ring_pos % win;
    ring_sum = ring_sum - int'(ring[pos]);
    ring[pos] = smp;
    ring_sum = ring_sum + int'(smp);
    pos++;
    if (pos >= win) begin
      pos       = 0;
      ring_full = 1'b1;
    end
    ring_pos = pos;
    // Before the window fills, divide by the samples seen since the clear.
    count = ring_full ? win : pos;
    if (count < 1) count = 1;
    avg = ring_sum / count;  // int division truncates toward zero
    m.average       = smavg_pkg::SAMPLE_BITS'(avg);
    m.window_filled = ring_full;
    expected_means.push_back(m);
  endfunction

  // --------------------------------------------------------------------------
  // Clock and timeout
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("** simple_moving_average: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random stall bursts on ready, none once quiet is set
  // --------------------------------------------------------------------------
  initial begin : result_sink
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
    end
  end

  // Each accepted result is checked against the oldest predicted mean.
  always @(posedge clk_i) begin : check_results
    mean_t exp_m;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_means.size() == 0) begin
        $error("unexpected result: average %0d window_filled %0b",
               res_if.average, res_if.window_filled);
        n_errors++;
      end else begin
        exp_m = expected_means.pop_front();
        if (res_if.average !== exp_m.average) begin
          $error("average: expected %0d, got %0d", exp_m.average, res_if.average);
          n_errors++;
        end
        if (res_if.window_filled !== exp_m.window_filled) begin
          $error("window_filled: expected %0b, got %0b",
                 exp_m.window_filled, res_if.window_filled);
          n_errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Valid is only lowered in an idle burst or at a drain, so back-to-back
  // requests keep it high without a same-step lower/raise.
  task automatic send_request(input logic cmd,
                              input logic signed [smavg_pkg::SAMPLE_BITS-1:0] smp);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    req_if.valid  <= 1'b1;
    req_if.cmd    <= cmd;
    req_if.sample <= smp;
    do @(posedge clk_i); while (!req_if.ready);
    predict_mean(cmd, smp);
  endtask

  task automatic send_sample(input logic signed [smavg_pkg::SAMPLE_BITS-1:0] smp);
    send_request(smavg_pkg::CMD_SAMPLE, smp);
  endtask

  // Waits until every mean has come back, then lets a trailing clear settle.
  task automatic drain();
    req_if.valid <= 1'b0;
    while (expected_means.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Window writes happen only with the filter idle; each write also clears.
  task automatic write_window(input logic [smavg_pkg::CFG_W-1:0] wl);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= wl;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    win_len_q = wl;
    clear_ring();
  endtask

  // Weighted toward the rails and toward small values near zero.
  function automatic logic signed [smavg_pkg::SAMPLE_BITS-1:0] rand_sample();
    logic signed [smavg_pkg::SAMPLE_BITS-1:0] s;
    case ($urandom_range(0, 9))
      0:       s = 16'sh7FFF;
      1:       s = 16'sh8000;
      2:       s = smavg_pkg::SAMPLE_BITS'($urandom_range(0, 16) - 8);
      default: s = smavg_pkg::SAMPLE_BITS'($urandom);
    endcase
    return s;
  endfunction

  // Mostly samples, with a rare clear carrying a junk sample field.
  task automatic random_requests(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 49) == 0) begin
        send_request(smavg_pkg::CMD_CLEAR, smavg_pkg::SAMPLE_BITS'($urandom));
      end else begin
        send_sample(rand_sample());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset window of 8: rails, fill, wrap, and negative means truncated toward zero.
  task automatic test_default_window();
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'sh0001);
    send_sample(-16'sd1);
    send_sample(16'sh8000);  // first sample to replace an old entry
    write_window(smavg_pkg::CFG_W'(8));
    send_sample(-16'sd3);
    send_sample(-16'sd2);    // -5 / 2 rounds toward zero
  endtask

  // A clear ignores its sample field and returns nothing.
  task automatic test_clear_command();
    send_request(smavg_pkg::CMD_CLEAR, 16'sh5A5A);
    send_sample(16'sd100);
    send_request(smavg_pkg::CMD_CLEAR, 16'shA5A5);
    send_sample(-16'sd7);
  endtask

  // Zero acts as one, above the store size saturates, plus both true ends.
  task automatic test_window_edges();
    write_window(smavg_pkg::CFG_W'(0));
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    write_window(smavg_pkg::CFG_W'(127));
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    write_window(smavg_pkg::CFG_W'(smavg_pkg::MAX_WINDOW));
    send_sample(16'sh7FFF);
    write_window(smavg_pkg::CFG_W'(1));
    send_sample(-16'sd1);
  endtask

  // Random content across a spread of window settings.
  task automatic test_random_windows();
    logic [smavg_pkg::CFG_W-1:0] lens [$];
    lens = '{smavg_pkg::CFG_W'(1), smavg_pkg::CFG_W'(2), smavg_pkg::CFG_W'(127),
             smavg_pkg::CFG_W'(0), smavg_pkg::CFG_W'(64), smavg_pkg::CFG_W'(65),
             smavg_pkg::CFG_W'(3), smavg_pkg::CFG_W'(5), smavg_pkg::CFG_W'(7),
             smavg_pkg::CFG_W'($urandom_range(1, 16)),
             smavg_pkg::CFG_W'($urandom_range(0, 127)),
             smavg_pkg::CFG_W'(12), smavg_pkg::CFG_W'(33)};
    foreach (lens[i]) begin
      write_window(lens[i]);
      // Long windows need more items to fill and wrap.
      random_requests((lens[i] >= 32) ? 130 : 50);
    end
  endtask

  // Last stretch at full rate with no idling on either side.
  task automatic test_full_rate();
    quiet = 1'b1;
    write_window(smavg_pkg::CFG_W'($urandom_range(1, 20)));
    random_requests(120);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    req_if.valid  = 1'b0;
    req_if.cmd    = smavg_pkg::CMD_SAMPLE;
    req_if.sample = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    win_len_q     = smavg_pkg::WINDOW_RESET;
    clear_ring();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_window();
    test_clear_command();
    test_window_edges();
    test_random_windows();
    test_full_rate();

    drain();
    if (n_errors == 0) begin
      $display("** simple_moving_average: PASSED **");
    end else begin
      $display("** simple_moving_average: FAILED **");
    end
    $finish;
  end

endmodule
